// File: rtl/rstri_pkg.sv
// Shared widths, register codes and pipeline depths for the stereo triangulator.
package rstri_pkg;

	// Field widths.
	localparam int PIX_W     = 16;   // Q12.4 pixel coordinate
	localparam int BASE_W    = 20;   // Q4.16 baseline
	localparam int PROD_W    = PIX_W + BASE_W;   // magnitude of a numerator
	localparam int NUM_W     = PROD_W + 2;       // 2*|num| + d, rounding folded in
	localparam int DEN_W     = PIX_W + 1;        // 2*d
	localparam int COORD_W   = 32;
	localparam int DEPTH_W   = 31;

	// Stream and configuration port widths.
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Divider pipeline: quotient bits resolved per stage and stage count.
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = NUM_W / DIV_STEP;

	// Front stages (prepare, multiply, form dividend), divider, output register.
	localparam int NUM_STAGES = 3 + DIV_STAGES + 1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL    = 8'd0,
		REG_BASELINE = 8'd1,
		REG_CENTER_U = 8'd2,
		REG_CENTER_V = 8'd3
	} cfg_reg_t;

endpackage

// File: rtl/rstri_div.sv
// Pipelined restoring divider lane: unsigned dividend over unsigned divisor.
module rstri_div (
	input  logic                                clk,
	input  logic [rstri_pkg::DIV_STAGES-1:0]    en,
	input  logic [rstri_pkg::NUM_W-1:0]         num,
	input  logic [rstri_pkg::DEN_W-1:0]         den,
	input  logic                                neg,
	output logic [rstri_pkg::NUM_W-1:0]         quo,
	output logic                                neg_out
);
	import rstri_pkg::*;

	// Per stage: partial remainder, dividend/quotient shift word, divisor, sign.
	logic [DEN_W-1:0] rem_s  [DIV_STAGES];
	logic [NUM_W-1:0] word_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s  [DIV_STAGES];
	logic             neg_s  [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] word_in;
		logic [DEN_W-1:0] den_in;
		logic             neg_in;
		logic [DEN_W-1:0] rem_nx;
		logic [NUM_W-1:0] word_nx;

		// Take the previous stage, or the lane inputs at the first stage.
		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign word_in = num;
			assign den_in  = den;
			assign neg_in  = neg;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign word_in = word_s[j-1];
			assign den_in  = den_s[j-1];
			assign neg_in  = neg_s[j-1];
		end

		// Resolve DIV_STEP quotient bits: shift in a dividend bit, trial subtract.
		always_comb begin
			logic [DEN_W+1:0] trial;
			rem_nx  = rem_in;
			word_nx = word_in;
			for (int k = 0; k < DIV_STEP; k++) begin
				trial = {1'b0, rem_nx, word_nx[NUM_W-1]} - {2'b00, den_in};
				if (!trial[DEN_W+1]) begin
					rem_nx  = trial[DEN_W-1:0];
					word_nx = {word_nx[NUM_W-2:0], 1'b1};
				end else begin
					rem_nx  = {rem_nx[DEN_W-2:0], word_nx[NUM_W-1]};
					word_nx = {word_nx[NUM_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]  <= rem_nx;
				word_s[j] <= word_nx;
				den_s[j]  <= den_in;
				neg_s[j]  <= neg_in;
			end
		end
	end

	// After the last stage the shift word holds the quotient.
	assign quo     = word_s[DIV_STAGES-1];
	assign neg_out = neg_s[DIV_STAGES-1];

endmodule

// File: rtl/rectified_stereo_triangulator.sv
// Inputs pass the front stages, divider lanes and output register to m_tdata/m_tuser.
// Throughput: one point pair per cycle when not stalled; set by the 19-stage divider
// lanes (two quotient bits per stage), which take a new dividend every cycle.
// Each stage holds its item while the next stage is full and stalled.
// Reset (arst_n low, asynchronous) clears all valid bits and the configuration registers.
module rectified_stereo_triangulator (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rstri_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rstri_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// left_u [15:0], left_v [31:16], right_u [47:32]
	input  logic [rstri_pkg::IN_DATA_W-1:0]    s_tdata,
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pos_x [31:0], pos_y [63:32], pos_z [94:64], zero [95]
	output logic [rstri_pkg::OUT_DATA_W-1:0]   m_tdata,
	// disparity_clamped [0], saturated [1]
	output logic [rstri_pkg::OUT_USER_W-1:0]   m_tuser
);
	import rstri_pkg::*;

	localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(32'h7FFF_FFFF);
	localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(33'h0_8000_0000);

	// Configuration registers; every request is taken at once.
	logic [PIX_W-1:0]  focal_q;
	logic [BASE_W-1:0] base_q;
	logic [PIX_W-1:0]  cu_q;
	logic [PIX_W-1:0]  cv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= '0;
			base_q  <= '0;
			cu_q    <= '0;
			cv_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FOCAL:    focal_q <= cfg_data[PIX_W-1:0];
				REG_BASELINE: base_q  <= cfg_data[BASE_W-1:0];
				REG_CENTER_U: cu_q    <= cfg_data[PIX_W-1:0];
				REG_CENTER_V: cv_q    <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits and per-stage load enables; a stage loads when empty or draining.
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   rdy;

	always_comb begin
		rdy[NUM_STAGES] = m_tready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: disparity with its floor, magnitudes and signs of the offsets.
	logic [PIX_W-1:0] lu, lv, ru;
	assign lu = s_tdata[15:0];
	assign lv = s_tdata[31:16];
	assign ru = s_tdata[47:32];

	logic [PIX_W-1:0] disp_s1, mx_s1, my_s1;
	logic             sx_s1, sy_s1, clamp_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			if (lu > ru) begin
				disp_s1  <= lu - ru;
				clamp_s1 <= 1'b0;
			end else begin
				disp_s1  <= PIX_W'(1);
				clamp_s1 <= 1'b1;
			end
			sx_s1 <= (lu < cu_q);
			mx_s1 <= (lu < cu_q) ? (cu_q - lu) : (lu - cu_q);
			sy_s1 <= (lv < cv_q);
			my_s1 <= (lv < cv_q) ? (cv_q - lv) : (lv - cv_q);
		end
	end

	// Stage 2: the three products with the baseline.
	logic [PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic [PIX_W-1:0]  disp_s2;
	logic              sx_s2, sy_s2, clamp_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			px_s2    <= PROD_W'(mx_s1) * PROD_W'(base_q);
			py_s2    <= PROD_W'(my_s1) * PROD_W'(base_q);
			pz_s2    <= PROD_W'(focal_q) * PROD_W'(base_q);
			disp_s2  <= disp_s1;
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			clamp_s2 <= clamp_s1;
		end
	end

	// Stage 3: dividends 2*|num| + d over divisor 2*d give round-half-away quotients.
	logic [NUM_W-1:0] nx_s3, ny_s3, nz_s3;
	logic [DEN_W-1:0] den_s3;
	logic             sx_s3, sy_s3, clamp_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			nx_s3    <= {1'b0, px_s2, 1'b0} + NUM_W'(disp_s2);
			ny_s3    <= {1'b0, py_s2, 1'b0} + NUM_W'(disp_s2);
			nz_s3    <= {1'b0, pz_s2, 1'b0} + NUM_W'(disp_s2);
			den_s3   <= {disp_s2, 1'b0};
			sx_s3    <= sx_s2;
			sy_s3    <= sy_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	// Divider lanes, one per coordinate.
	logic [DIV_STAGES-1:0] div_en;
	logic [NUM_W-1:0]      qx, qy, qz;
	logic                  sx_d, sy_d, sz_unused;

	assign div_en = rdy[3 +: DIV_STAGES];

	rstri_div u_div_x (
		.clk(clk), .en(div_en), .num(nx_s3), .den(den_s3), .neg(sx_s3),
		.quo(qx), .neg_out(sx_d)
	);
	rstri_div u_div_y (
		.clk(clk), .en(div_en), .num(ny_s3), .den(den_s3), .neg(sy_s3),
		.quo(qy), .neg_out(sy_d)
	);
	rstri_div u_div_z (
		.clk(clk), .en(div_en), .num(nz_s3), .den(den_s3), .neg(1'b0),
		.quo(qz), .neg_out(sz_unused)
	);

	// Clamp flag rides alongside the divider stages.
	logic clamp_sd [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (div_en[0]) begin
			clamp_sd[0] <= clamp_s3;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (div_en[k]) begin
				clamp_sd[k] <= clamp_sd[k-1];
			end
		end
	end

	// Sign restore and saturation of the quotients.
	logic [COORD_W-1:0] x_c, y_c;
	logic [DEPTH_W-1:0] z_c;
	logic               satx, saty, satz;

	always_comb begin
		if (sx_d) begin
			satx = (qx > NEG_MAX);
			x_c  = satx ? 32'h8000_0000 : COORD_W'(~qx + NUM_W'(1));
		end else begin
			satx = (qx > POS_MAX);
			x_c  = satx ? 32'h7FFF_FFFF : qx[COORD_W-1:0];
		end
		if (sy_d) begin
			saty = (qy > NEG_MAX);
			y_c  = saty ? 32'h8000_0000 : COORD_W'(~qy + NUM_W'(1));
		end else begin
			saty = (qy > POS_MAX);
			y_c  = saty ? 32'h7FFF_FFFF : qy[COORD_W-1:0];
		end
		satz = (qz > POS_MAX) || sz_unused;
		z_c  = satz ? 31'h7FFF_FFFF : qz[DEPTH_W-1:0];
	end

	// Output register.
	logic [COORD_W-1:0] x_so, y_so;
	logic [DEPTH_W-1:0] z_so;
	logic               clamp_so, sat_so;

	always_ff @(posedge clk) begin
		if (rdy[NUM_STAGES-1]) begin
			x_so     <= x_c;
			y_so     <= y_c;
			z_so     <= z_c;
			clamp_so <= clamp_sd[DIV_STAGES-1];
			sat_so   <= satx || saty || satz;
		end
	end

	assign m_tvalid = vld_q[NUM_STAGES-1];
	assign m_tdata  = {1'b0, z_so, y_so, x_so};
	assign m_tuser  = {sat_so, clamp_so};

endmodule

// File: rtl/rstri_chk.sv
// Port-level checker for the stereo triangulator, bound to the top level.
module rstri_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_ready,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [rstri_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic [rstri_pkg::OUT_USER_W-1:0]   m_tuser
);

	// A stalled result holds its value until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// With the output free to move, the pipeline can always take a request.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input blocked while output drains");

	// The padding bit above the depth field is always zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[95])
		else $error("padding bit set");

	// Configuration requests are never back-pressured.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind rectified_stereo_triangulator rstri_chk u_rstri_chk (.*);
